>>> rtl/midpoint_ellipse_rasterizer_core_defines.svh
// Assertion helpers used by the checker file.
// Each macro is clocked on clk and masked while rst is high.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_CORE_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_CORE_DEFINES_SVH

// Same-cycle implication.
`define MER_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mer assertion failed");

// Next-cycle implication.
`define MER_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mer assertion failed");

`endif

>>> rtl/mer_pkg.sv
`timescale 1ns / 1ps

package mer_pkg;

  // Field widths
  localparam int COORD_BITS  = 12;
  localparam int RADIUS_BITS = 10;
  localparam int OUT_BITS    = COORD_BITS + 2;
  // Offsets carry one bit of headroom over a radius
  localparam int OFS_BITS    = RADIUS_BITS + 1;
  localparam int SQ_BITS     = 2 * RADIUS_BITS;
  // 2*r^2*offset
  localparam int SLOPE_BITS  = 3 * RADIUS_BITS + 2;
  // Widest multiplier operand is (2x+1)^2
  localparam int MUL_BITS    = 2 * RADIUS_BITS + 4;
  localparam int DEC_BITS    = 2 * MUL_BITS;

  // Rounding bias in quarter units (+0.5)
  localparam logic [DEC_BITS-1:0] ROUND_BIAS = DEC_BITS'(2);

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_LOAD,
    UOP_SQ_RX,
    UOP_SQ_RY,
    UOP_MUL_SLOPE,
    UOP_INIT_ONE,
    UOP_ROUND,
    UOP_STEP_ONE,
    UOP_STEP_ONE_DEC,
    UOP_STEP_TWO,
    UOP_STEP_TWO_DEC,
    UOP_TX_SQ,
    UOP_MUL_TX,
    UOP_YM_SQ,
    UOP_MUL_YM,
    UOP_MUL_RR,
    UOP_INIT_TWO
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic out_load;
    logic out_blank;
    logic out_finished;
  } cmd_t;

  typedef struct packed {
    logic sx_lt_sy;
    logic oy_nz;
  } status_t;

endpackage

>>> rtl/mer_in_if.sv
`timescale 1ns / 1ps

interface mer_in_if import mer_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0] radius_x;
  logic [RADIUS_BITS-1:0] radius_y;

  modport source (
    output valid, operation, center_x, center_y, radius_x, radius_y,
    input  ready
  );
  modport sink (
    input  valid, operation, center_x, center_y, radius_x, radius_y,
    output ready
  );
endinterface

>>> rtl/mer_out_if.sv
`timescale 1ns / 1ps

interface mer_out_if import mer_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] pt0_x;
  logic signed [OUT_BITS-1:0] pt0_y;
  logic signed [OUT_BITS-1:0] pt1_x;
  logic signed [OUT_BITS-1:0] pt1_y;
  logic signed [OUT_BITS-1:0] pt2_x;
  logic signed [OUT_BITS-1:0] pt2_y;
  logic signed [OUT_BITS-1:0] pt3_x;
  logic signed [OUT_BITS-1:0] pt3_y;
  logic                       points_valid;
  logic                       finished;

  modport source (
    output valid, pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y,
           points_valid, finished,
    input  ready
  );
  modport sink (
    input  valid, pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y,
           points_valid, finished,
    output ready
  );
endinterface

>>> rtl/mer_datapath.sv
`timescale 1ns / 1ps

module mer_datapath import mer_pkg::*; (
  input  logic                       clk,
  input  cmd_t                       cmd,
  output status_t                    status,
  input  logic [COORD_BITS-1:0]      center_x,
  input  logic [COORD_BITS-1:0]      center_y,
  input  logic [RADIUS_BITS-1:0]     radius_x,
  input  logic [RADIUS_BITS-1:0]     radius_y,
  output logic signed [OUT_BITS-1:0] pt0_x,
  output logic signed [OUT_BITS-1:0] pt0_y,
  output logic signed [OUT_BITS-1:0] pt1_x,
  output logic signed [OUT_BITS-1:0] pt1_y,
  output logic signed [OUT_BITS-1:0] pt2_x,
  output logic signed [OUT_BITS-1:0] pt2_y,
  output logic signed [OUT_BITS-1:0] pt3_x,
  output logic signed [OUT_BITS-1:0] pt3_y,
  output logic                       points_valid,
  output logic                       finished
);

  logic [COORD_BITS-1:0]      cx, cy;
  logic [RADIUS_BITS-1:0]     rx, ry;
  logic [SQ_BITS-1:0]         rxsq, rysq;
  logic [OFS_BITS-1:0]        ox, oy;
  logic [SLOPE_BITS-1:0]      sx, sy;
  logic signed [DEC_BITS-1:0] dec;
  logic signed [DEC_BITS-1:0] q;
  logic [DEC_BITS-1:0]        p;
  logic                       moved;

  logic [MUL_BITS-1:0]        mul_a, mul_b;
  logic [DEC_BITS-1:0]        mul_p;
  logic [OFS_BITS:0]          tx;
  logic [OFS_BITS-1:0]        ym;
  logic [SLOPE_BITS-1:0]      sx_step, sy_step;
  logic [DEC_BITS-1:0]        p_x4;
  logic signed [DEC_BITS-1:0] q_adj;
  logic [OUT_BITS-1:0]        xp, xm, yp, yneg;

  assign tx      = {ox, 1'b1};
  assign ym      = oy - OFS_BITS'(1);
  assign sx_step = SLOPE_BITS'({rysq, 1'b0});
  assign sy_step = SLOPE_BITS'({rxsq, 1'b0});
  assign p_x4    = {p[DEC_BITS-3:0], 2'b00};

  // Truncate toward zero when dividing by four
  assign q_adj = q + DEC_BITS'({q[DEC_BITS-1], q[DEC_BITS-1]});

  assign status.sx_lt_sy = (sx < sy);
  assign status.oy_nz    = |oy;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.uop)
      UOP_SQ_RX: begin
        mul_a = MUL_BITS'(rx);
        mul_b = MUL_BITS'(rx);
      end
      UOP_SQ_RY: begin
        mul_a = MUL_BITS'(ry);
        mul_b = MUL_BITS'(ry);
      end
      UOP_MUL_SLOPE: begin
        mul_a = MUL_BITS'(rxsq);
        mul_b = MUL_BITS'(ry);
      end
      UOP_TX_SQ: begin
        mul_a = MUL_BITS'(tx);
        mul_b = MUL_BITS'(tx);
      end
      UOP_MUL_TX: begin
        mul_a = p[MUL_BITS-1:0];
        mul_b = MUL_BITS'(rysq);
      end
      UOP_YM_SQ: begin
        mul_a = MUL_BITS'(ym);
        mul_b = MUL_BITS'(ym);
      end
      UOP_MUL_YM: begin
        mul_a = p[MUL_BITS-1:0];
        mul_b = MUL_BITS'(rxsq);
      end
      UOP_MUL_RR: begin
        mul_a = MUL_BITS'(rxsq);
        mul_b = MUL_BITS'(rysq);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.uop)
      UOP_LOAD: begin
        cx <= center_x;
        cy <= center_y;
        rx <= radius_x;
        ry <= radius_y;
        ox <= '0;
        oy <= OFS_BITS'(radius_y);
        sx <= '0;
      end
      UOP_SQ_RX: rxsq <= mul_p[SQ_BITS-1:0];
      UOP_SQ_RY: rysq <= mul_p[SQ_BITS-1:0];
      UOP_MUL_SLOPE, UOP_TX_SQ, UOP_MUL_TX, UOP_MUL_YM: p <= mul_p;
      UOP_INIT_ONE: begin
        sy <= {p[SLOPE_BITS-2:0], 1'b0};
        q  <= DEC_BITS'({rysq, 2'b00}) + DEC_BITS'(rxsq) + ROUND_BIAS - p_x4;
      end
      UOP_ROUND: dec <= q_adj >>> 2;
      UOP_STEP_ONE: begin
        ox    <= ox + OFS_BITS'(1);
        sx    <= sx + sx_step;
        moved <= ~dec[DEC_BITS-1];
        if (!dec[DEC_BITS-1]) begin
          oy <= oy - OFS_BITS'(1);
          sy <= sy - sy_step;
        end
      end
      UOP_STEP_ONE_DEC: begin
        dec <= dec + DEC_BITS'(rysq) + DEC_BITS'(sx)
             - (moved ? DEC_BITS'(sy) : '0);
      end
      UOP_STEP_TWO: begin
        // Both coordinates move unless the decision is strictly positive
        oy    <= oy - OFS_BITS'(1);
        sy    <= sy - sy_step;
        moved <= dec[DEC_BITS-1] | ~(|dec);
        if (dec[DEC_BITS-1] || !(|dec)) begin
          ox <= ox + OFS_BITS'(1);
          sx <= sx + sx_step;
        end
      end
      UOP_STEP_TWO_DEC: begin
        dec <= dec + DEC_BITS'(rxsq) - DEC_BITS'(sy)
             + (moved ? DEC_BITS'(sx) : '0);
      end
      UOP_YM_SQ: begin
        q <= p;
        p <= mul_p;
      end
      UOP_MUL_RR: begin
        q <= q + p_x4;
        p <= mul_p;
      end
      UOP_INIT_TWO: q <= q - p_x4 + ROUND_BIAS;
      default: ;
    endcase
  end

  // Four quadrant mirrors, wrapped to the output width
  assign xp   = OUT_BITS'(cx) + OUT_BITS'(ox);
  assign xm   = OUT_BITS'(cx) - OUT_BITS'(ox);
  assign yp   = OUT_BITS'(cy) + OUT_BITS'(oy);
  assign yneg = OUT_BITS'(cy) - OUT_BITS'(oy);

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_blank) begin
        pt0_x        <= '0;
        pt0_y        <= '0;
        pt1_x        <= '0;
        pt1_y        <= '0;
        pt2_x        <= '0;
        pt2_y        <= '0;
        pt3_x        <= '0;
        pt3_y        <= '0;
        points_valid <= 1'b0;
        finished     <= 1'b1;
      end else begin
        pt0_x        <= xp;
        pt0_y        <= yp;
        pt1_x        <= xm;
        pt1_y        <= yp;
        pt2_x        <= xp;
        pt2_y        <= yneg;
        pt3_x        <= xm;
        pt3_y        <= yneg;
        points_valid <= 1'b1;
        finished     <= cmd.out_finished;
      end
    end
  end

endmodule

>>> rtl/mer_ctrl.sv
`timescale 1ns / 1ps

module mer_ctrl import mer_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_operation,
  output logic    in_ready,
  input  logic    out_ready,
  output logic    out_valid,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_SQ_RX     = 17'h00002,
    S_SQ_RY     = 17'h00004,
    S_MUL_SLOPE = 17'h00008,
    S_INIT_ONE  = 17'h00010,
    S_ROUND_ONE = 17'h00020,
    S_DEC_ONE   = 17'h00040,
    S_CHOOSE    = 17'h00080,
    S_TX_SQ     = 17'h00100,
    S_MUL_TX    = 17'h00200,
    S_YM_SQ     = 17'h00400,
    S_MUL_YM    = 17'h00800,
    S_MUL_RR    = 17'h01000,
    S_INIT_TWO  = 17'h02000,
    S_ROUND_TWO = 17'h04000,
    S_DEC_TWO   = 17'h08000,
    S_EMIT      = 17'h10000
  } state_t;

  typedef enum logic [3:0] {
    REG_IDLE = 4'b0001,
    REG_ONE  = 4'b0010,
    REG_TWO  = 4'b0100,
    REG_DONE = 4'b1000
  } region_t;

  state_t  state, state_next;
  region_t region, region_next;
  logic    blank, blank_next;
  logic    out_valid_next;
  logic    in_fire;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Sequencer
  always_comb begin
    state_next       = state;
    region_next      = region;
    blank_next       = blank;
    cmd.uop          = UOP_NONE;
    cmd.out_load     = 1'b0;
    cmd.out_blank    = blank;
    cmd.out_finished = (region == REG_DONE);
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          blank_next = 1'b0;
          if (in_operation == OP_START) begin
            cmd.uop    = UOP_LOAD;
            state_next = S_SQ_RX;
          end else if (region == REG_ONE) begin
            cmd.uop    = UOP_STEP_ONE;
            state_next = S_DEC_ONE;
          end else if (region == REG_TWO) begin
            cmd.uop    = UOP_STEP_TWO;
            state_next = S_DEC_TWO;
          end else begin
            blank_next = 1'b1;
            state_next = S_EMIT;
          end
        end
      end
      S_SQ_RX: begin
        cmd.uop    = UOP_SQ_RX;
        state_next = S_SQ_RY;
      end
      S_SQ_RY: begin
        cmd.uop    = UOP_SQ_RY;
        state_next = S_MUL_SLOPE;
      end
      S_MUL_SLOPE: begin
        cmd.uop    = UOP_MUL_SLOPE;
        state_next = S_INIT_ONE;
      end
      S_INIT_ONE: begin
        cmd.uop    = UOP_INIT_ONE;
        state_next = S_ROUND_ONE;
      end
      S_ROUND_ONE: begin
        cmd.uop    = UOP_ROUND;
        state_next = S_CHOOSE;
      end
      S_DEC_ONE: begin
        cmd.uop    = UOP_STEP_ONE_DEC;
        state_next = S_CHOOSE;
      end
      // Stay in region one, enter region two, or stop
      S_CHOOSE: begin
        if (status.sx_lt_sy) begin
          region_next = REG_ONE;
          state_next  = S_EMIT;
        end else if (status.oy_nz) begin
          state_next = S_TX_SQ;
        end else begin
          region_next = REG_DONE;
          state_next  = S_EMIT;
        end
      end
      S_TX_SQ: begin
        cmd.uop    = UOP_TX_SQ;
        state_next = S_MUL_TX;
      end
      S_MUL_TX: begin
        cmd.uop    = UOP_MUL_TX;
        state_next = S_YM_SQ;
      end
      S_YM_SQ: begin
        cmd.uop    = UOP_YM_SQ;
        state_next = S_MUL_YM;
      end
      S_MUL_YM: begin
        cmd.uop    = UOP_MUL_YM;
        state_next = S_MUL_RR;
      end
      S_MUL_RR: begin
        cmd.uop    = UOP_MUL_RR;
        state_next = S_INIT_TWO;
      end
      S_INIT_TWO: begin
        cmd.uop    = UOP_INIT_TWO;
        state_next = S_ROUND_TWO;
      end
      S_ROUND_TWO: begin
        cmd.uop     = UOP_ROUND;
        region_next = REG_TWO;
        state_next  = S_EMIT;
      end
      S_DEC_TWO: begin
        cmd.uop     = UOP_STEP_TWO_DEC;
        region_next = status.oy_nz ? REG_TWO : REG_DONE;
        state_next  = S_EMIT;
      end
      // Wait for the output register to free up
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      region    <= REG_IDLE;
      blank     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      region    <= region_next;
      blank     <= blank_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/midpoint_ellipse_rasterizer_core.sv
`timescale 1ns / 1ps
// Channel  Dir  Transaction payload
// in_ch    in   operation, center_x, center_y, radius_x, radius_y
// out_ch   out  pt0..pt3 x/y, points_valid, finished
//
// One transaction in at a time; the multiplier is shared, one product per cycle.
// Region-one step: DEC_ONE, CHOOSE, EMIT; handover to region two adds TX_SQ to ROUND_TWO.
// Region-two step: DEC_TWO, EMIT. Step while idle/done: EMIT. Start: SQ_RX to ROUND_ONE,
// CHOOSE, EMIT, with the handover (five products) when it goes straight into region two.
// Output register lets the next transaction in while a result waits on out_ch.
// rst is synchronous, active high; it clears the sequencer, region and out valid.
module midpoint_ellipse_rasterizer_core import mer_pkg::*; (
  input logic      clk,
  input logic      rst,
  mer_in_if.sink   in_ch,
  mer_out_if.source out_ch
);

  cmd_t    cmd;
  status_t status;

  mer_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .status       (status),
    .cmd          (cmd)
  );

  mer_datapath u_datapath (
    .clk          (clk),
    .cmd          (cmd),
    .status       (status),
    .center_x     (in_ch.center_x),
    .center_y     (in_ch.center_y),
    .radius_x     (in_ch.radius_x),
    .radius_y     (in_ch.radius_y),
    .pt0_x        (out_ch.pt0_x),
    .pt0_y        (out_ch.pt0_y),
    .pt1_x        (out_ch.pt1_x),
    .pt1_y        (out_ch.pt1_y),
    .pt2_x        (out_ch.pt2_x),
    .pt2_y        (out_ch.pt2_y),
    .pt3_x        (out_ch.pt3_x),
    .pt3_y        (out_ch.pt3_y),
    .points_valid (out_ch.points_valid),
    .finished     (out_ch.finished)
  );

endmodule

>>> rtl/mer_checker.sv
`timescale 1ns / 1ps
`include "midpoint_ellipse_rasterizer_core_defines.svh"

module mer_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_points_valid,
  input logic out_finished
);

  // A result held back stays offered
  `MER_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A stalled result keeps its flags
  `MER_ASSERT_NEXT(a_out_flags_stable, out_valid && !out_ready,
                   $stable(out_points_valid) && $stable(out_finished))

  // A blank point set always reports finished
  `MER_ASSERT_NOW(a_blank_finished, out_valid && !out_points_valid, out_finished)

  // One transaction in flight: ready drops right after an accept
  `MER_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

endmodule

bind midpoint_ellipse_rasterizer_core mer_checker u_mer_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_points_valid (out_ch.points_valid),
  .out_finished     (out_ch.finished)
);
